/* rtl/bld_pkg.sv */
`default_nettype none

package bld_pkg;

  // Number of slots in the linear array.
  localparam int unsigned DEPTH = 8;

  // Widths that follow from the depth and from the item fields.
  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = IDX_W + 1;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned OCC_W   = 4;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 40;

  // Last slot of the array.
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  // Request operations.
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_LEFT  = 2'd0,
    MODE_PUSH_RIGHT = 2'd1,
    MODE_POP_LEFT   = 2'd2,
    MODE_POP_RIGHT  = 2'd3
  } mode_e;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_DONE    = 2'd0,
    STAT_NO_ROOM = 2'd1,
    STAT_EMPTY   = 2'd2
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SEND
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;  // Request is taken: update indices, access the slot array.
    logic load;  // Slot read data is ready: fill the result register.
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/bld_ram.sv */
`default_nettype none

module bld_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/bld_ctrl.sv */
`default_nettype none

module bld_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          out_ready_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  output bld_pkg::cmd_t      cmd_o
);

  bld_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bld_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state: take a request, wait in ST_LOAD for the slot read, then offer the result.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bld_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = bld_pkg::ST_LOAD;
        end
      end
      bld_pkg::ST_LOAD: begin
        state_d = bld_pkg::ST_SEND;
      end
      bld_pkg::ST_SEND: begin
        if (out_ready_i) begin
          state_d = bld_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bld_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs decoded from the state.
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      bld_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.exec = in_valid_i;
      end
      bld_pkg::ST_LOAD: begin
        cmd_o.load = 1'b1;
      end
      bld_pkg::ST_SEND: begin
        out_valid_o = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/bld_dpath.sv */
`default_nettype none

module bld_dpath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire bld_pkg::cmd_t                cmd_i,
  input  wire logic [bld_pkg::MODE_W-1:0]   mode_i,
  input  wire logic [bld_pkg::DATA_W-1:0]   value_i,
  output logic      [bld_pkg::DATA_W-1:0]   popped_value_o,
  output logic      [bld_pkg::STAT_W-1:0]   status_o,
  output logic      [bld_pkg::OCC_W-1:0]    occupancy_o
);

  logic [bld_pkg::IDX_W-1:0] front_q, front_d;
  logic [bld_pkg::IDX_W-1:0] rear_q, rear_d;
  logic                      empty_q, empty_d;
  bld_pkg::status_e          stat_q, stat_d;
  logic                      pop_ok_q, pop_ok_d;

  logic                      we;
  logic [bld_pkg::IDX_W-1:0] waddr;
  logic [bld_pkg::IDX_W-1:0] raddr;
  logic [bld_pkg::DATA_W-1:0] rdata;

  logic [bld_pkg::CNT_W-1:0]           held;
  logic [bld_pkg::CNT_W+bld_pkg::OCC_W-1:0] held_ext;

  logic [bld_pkg::DATA_W-1:0] popped_q;
  logic [bld_pkg::STAT_W-1:0] status_q;
  logic [bld_pkg::OCC_W-1:0]  occ_q;

  // Decode the request against the current bounds.
  always_comb begin
    front_d  = front_q;
    rear_d   = rear_q;
    empty_d  = empty_q;
    stat_d   = bld_pkg::STAT_DONE;
    pop_ok_d = 1'b0;
    we       = 1'b0;
    waddr    = '0;
    raddr    = front_q;
    unique case (bld_pkg::mode_e'(mode_i))
      bld_pkg::MODE_PUSH_LEFT: begin
        if (empty_q) begin
          front_d = '0;
          rear_d  = '0;
          empty_d = 1'b0;
          we      = 1'b1;
        end else if (front_q == '0) begin
          stat_d = bld_pkg::STAT_NO_ROOM;
        end else begin
          front_d = front_q - 1'b1;
          waddr   = front_q - 1'b1;
          we      = 1'b1;
        end
      end
      bld_pkg::MODE_PUSH_RIGHT: begin
        if (empty_q) begin
          front_d = '0;
          rear_d  = '0;
          empty_d = 1'b0;
          we      = 1'b1;
        end else if (rear_q == bld_pkg::LAST_IDX) begin
          stat_d = bld_pkg::STAT_NO_ROOM;
        end else begin
          rear_d = rear_q + 1'b1;
          waddr  = rear_q + 1'b1;
          we     = 1'b1;
        end
      end
      bld_pkg::MODE_POP_LEFT: begin
        raddr = front_q;
        if (empty_q) begin
          stat_d = bld_pkg::STAT_EMPTY;
        end else begin
          pop_ok_d = 1'b1;
          if (front_q == rear_q) begin
            front_d = '0;
            rear_d  = '0;
            empty_d = 1'b1;
          end else begin
            front_d = front_q + 1'b1;
          end
        end
      end
      bld_pkg::MODE_POP_RIGHT: begin
        raddr = rear_q;
        if (empty_q) begin
          stat_d = bld_pkg::STAT_EMPTY;
        end else begin
          pop_ok_d = 1'b1;
          if (front_q == rear_q) begin
            front_d = '0;
            rear_d  = '0;
            empty_d = 1'b1;
          end else begin
            rear_d = rear_q - 1'b1;
          end
        end
      end
      default: begin
        stat_d = bld_pkg::STAT_DONE;
      end
    endcase
  end

  // Bounds registers change only when a request is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      rear_q  <= '0;
      empty_q <= 1'b1;
    end else if (cmd_i.exec) begin
      front_q <= front_d;
      rear_q  <= rear_d;
      empty_q <= empty_d;
    end
  end

  // Outcome of the request, held until the slot read data arrives.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      stat_q   <= stat_d;
      pop_ok_q <= pop_ok_d;
    end
  end

  // Slot array.
  bld_ram #(
    .WIDTH(bld_pkg::DATA_W),
    .DEPTH(bld_pkg::DEPTH)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (we & cmd_i.exec),
    .waddr_i(waddr),
    .wdata_i(value_i),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Elements held, reported modulo the field width.
  assign held     = {1'b0, rear_q} - {1'b0, front_q} + 1'b1;
  assign held_ext = {{bld_pkg::OCC_W{1'b0}}, held};

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      popped_q <= pop_ok_q ? rdata : '0;
      status_q <= stat_q;
      occ_q    <= empty_q ? '0 : held_ext[bld_pkg::OCC_W-1:0];
    end
  end

  assign popped_value_o = popped_q;
  assign status_o       = status_q;
  assign occupancy_o    = occ_q;

endmodule

`default_nettype wire

/* rtl/bounded_linear_deque_core.sv */
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata: mode, value
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: popped_value, status, occupancy
//
// The request transfer updates the indices and starts the registered slot RAM read;
// in ST_LOAD the read data is loaded into the result register, which is then offered.
// A new request is taken only after the result transfer.
// Reset clears the indices and sets the empty flag; slot contents are not cleared.
// A stall on m_axis holds the result and keeps s_axis_tready low.
`default_nettype none

module bounded_linear_deque_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [1:0] mode, [33:2] value, [39:34] zero
  input  wire logic [bld_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [31:0] popped_value, [33:32] status, [37:34] occupancy, [39:38] zero
  output logic      [bld_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

  bld_pkg::cmd_t              cmd;
  logic [bld_pkg::DATA_W-1:0] popped_value;
  logic [bld_pkg::STAT_W-1:0] status;
  logic [bld_pkg::OCC_W-1:0]  occupancy;

  // Sequencing of request, read and result transfer.
  bld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .cmd_o      (cmd)
  );

  // Indices, slot array and result register.
  bld_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .mode_i        (s_axis_tdata[1:0]),
    .value_i       (s_axis_tdata[33:2]),
    .popped_value_o(popped_value),
    .status_o      (status),
    .occupancy_o   (occupancy)
  );

  assign m_axis_tdata = {2'b00, occupancy, status, popped_value};

endmodule

`default_nettype wire

/* rtl/bld_checker.sv */
`default_nettype none

module bld_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [bld_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  logic s_xfer;

  assign s_xfer = s_axis_tvalid && s_axis_tready;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Every request transfer yields an offered result once the slot read has been loaded.
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer |-> ##2 m_axis_tvalid)
    else $error("result not offered two cycles after request");

  // Only one request is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer |=> !s_axis_tready)
    else $error("request taken while another is in flight");

  // No request is taken while a result waits.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while a result is pending");

  // The status field carries only defined codes, and the pad bits stay zero.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[33:32] == bld_pkg::STAT_DONE) ||
                       (m_axis_tdata[33:32] == bld_pkg::STAT_NO_ROOM) ||
                       (m_axis_tdata[33:32] == bld_pkg::STAT_EMPTY)) &&
                      (m_axis_tdata[39:38] == 2'd0))
    else $error("undefined status code or nonzero pad in result");

endmodule

bind bounded_linear_deque_core bld_checker u_bld_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire

/* tb/bounded_linear_deque_core_tb.sv */
`timescale 1ns / 1ps

module bounded_linear_deque_core_tb;

  localparam int unsigned RANDOM_ITEMS = 1030;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned HOLD_AT_ITEM = 400;
  localparam int unsigned DRAIN_CYCLES = 8;

  // Random phases that shape the mix of operations.
  localparam int unsigned PHASE_FILL = 0;
  localparam int unsigned PHASE_DRAIN = 1;
  localparam int unsigned PHASE_MIXED = 2;
  localparam int unsigned PHASE_SIDED = 3;

  // Receiver stall patterns.
  localparam int unsigned RX_ALWAYS = 0;
  localparam int unsigned RX_HALF = 1;
  localparam int unsigned RX_SLOW = 2;

  // One expected result of a request.
  typedef struct {
    logic [bld_pkg::DATA_W-1:0] popped;
    bld_pkg::status_e           status;
    logic [bld_pkg::OCC_W-1:0]  occ;
  } deque_result_t;

  // Deque predictor and the store of results still to come.
  class deque_scoreboard;
    logic [bld_pkg::DATA_W-1:0] slot_mem [bld_pkg::DEPTH];
    logic [bld_pkg::IDX_W-1:0]  front_idx;
    logic [bld_pkg::IDX_W-1:0]  rear_idx;
    bit                         empty;
    deque_result_t              pending_results[$];
    int unsigned                errors;

    function new();
      front_idx = '0;
      rear_idx  = '0;
      empty     = 1'b1;
      errors    = 0;
      foreach (slot_mem[i]) slot_mem[i] = '0;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // Take one element away from the given end and return to reset positions when it was alone.
    function void drop_one(bit from_left);
      if (front_idx == rear_idx) begin
        front_idx = '0;
        rear_idx  = '0;
        empty     = 1'b1;
      end else if (from_left) begin
        front_idx = front_idx + 1'b1;
      end else begin
        rear_idx = rear_idx - 1'b1;
      end
    endfunction

    // Work out the result of an accepted request and update the deque.
    function void note_request(bld_pkg::mode_e mode, logic [bld_pkg::DATA_W-1:0] value);
      deque_result_t              res;
      logic [bld_pkg::CNT_W-1:0]  held;
      res.popped = '0;
      res.status = bld_pkg::STAT_DONE;
      case (mode) inside
        bld_pkg::MODE_PUSH_LEFT, bld_pkg::MODE_PUSH_RIGHT: begin
          if (empty) begin
            front_idx   = '0;
            rear_idx    = '0;
            slot_mem[0] = value;
            empty       = 1'b0;
          end else if (mode == bld_pkg::MODE_PUSH_LEFT) begin
            if (front_idx == '0) begin
              res.status = bld_pkg::STAT_NO_ROOM;
            end else begin
              front_idx = front_idx - 1'b1;
              slot_mem[front_idx] = value;
            end
          end else begin
            if (rear_idx == bld_pkg::LAST_IDX) begin
              res.status = bld_pkg::STAT_NO_ROOM;
            end else begin
              rear_idx = rear_idx + 1'b1;
              slot_mem[rear_idx] = value;
            end
          end
        end
        bld_pkg::MODE_POP_LEFT: begin
          if (empty) begin
            res.status = bld_pkg::STAT_EMPTY;
          end else begin
            res.popped = slot_mem[front_idx];
            drop_one(1'b1);
          end
        end
        default: begin
          if (empty) begin
            res.status = bld_pkg::STAT_EMPTY;
          end else begin
            res.popped = slot_mem[rear_idx];
            drop_one(1'b0);
          end
        end
      endcase
      if (empty) begin
        held = '0;
      end else begin
        held = bld_pkg::CNT_W'(rear_idx) - bld_pkg::CNT_W'(front_idx) + 1'b1;
      end
      res.occ = bld_pkg::OCC_W'(held);
      pending_results.push_back(res);
    endfunction

    task report(string what, logic [bld_pkg::DATA_W-1:0] got,
                logic [bld_pkg::DATA_W-1:0] want);
      $display("MISMATCH %s: got %h, expected %h", what, got, want);
      errors++;
    endtask

    // Compare one result transfer with the oldest expectation.
    task check_result(logic [bld_pkg::M_TDATA_W-1:0] tdata);
      deque_result_t want;
      if (pending_results.size() == 0) begin
        report("result with none expected", bld_pkg::DATA_W'(tdata), '0);
        return;
      end
      want = pending_results.pop_front();
      if (tdata[31:0] !== want.popped) begin
        report("popped_value", tdata[31:0], want.popped);
      end
      if (tdata[33:32] !== want.status) begin
        report("status", bld_pkg::DATA_W'(tdata[33:32]), bld_pkg::DATA_W'(want.status));
      end
      if (tdata[37:34] !== want.occ) begin
        report("occupancy", bld_pkg::DATA_W'(tdata[37:34]), bld_pkg::DATA_W'(want.occ));
      end
    endtask
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [bld_pkg::S_TDATA_W-1:0] s_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [bld_pkg::M_TDATA_W-1:0] m_axis_tdata;

  deque_scoreboard sb;
  int unsigned     burst_left;
  int unsigned     sent_count;
  int unsigned     cycle_count;
  bit              hold_request;

  bounded_linear_deque_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock with a 10 ns period.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Run guard: ends a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bounded_linear_deque_core test failed");
      $finish;
    end
  end

  // Offer one request and hold it until the transfer, then maybe open a gap.
  task send_request(bld_pkg::mode_e mode, logic [bld_pkg::DATA_W-1:0] value);
    s_axis_tdata  <= {{(bld_pkg::S_TDATA_W - bld_pkg::DATA_W - bld_pkg::MODE_W){1'b0}},
                      value, mode};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(mode, value);
    sent_count++;
    if (sent_count == HOLD_AT_ITEM) hold_request = 1'b1;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      // Some bursts are long, which gives stretches without sender gaps.
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
    end
  endtask

  // Random element, with the extremes drawn more often than by chance.
  function automatic logic [bld_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Operation drawn with weights that depend on the phase.
  function automatic bld_pkg::mode_e pick_mode(int unsigned phase);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (phase)
      PHASE_FILL: begin
        if (roll < 80) begin
          return (roll < 40) ? bld_pkg::MODE_PUSH_LEFT : bld_pkg::MODE_PUSH_RIGHT;
        end
        return (roll < 90) ? bld_pkg::MODE_POP_LEFT : bld_pkg::MODE_POP_RIGHT;
      end
      PHASE_DRAIN: begin
        if (roll < 80) begin
          return (roll < 40) ? bld_pkg::MODE_POP_LEFT : bld_pkg::MODE_POP_RIGHT;
        end
        return (roll < 90) ? bld_pkg::MODE_PUSH_LEFT : bld_pkg::MODE_PUSH_RIGHT;
      end
      PHASE_SIDED: begin
        // Stack-like use on the right end, with a little noise.
        if (roll < 45) return bld_pkg::MODE_PUSH_RIGHT;
        if (roll < 90) return bld_pkg::MODE_POP_RIGHT;
        return (roll < 95) ? bld_pkg::MODE_PUSH_LEFT : bld_pkg::MODE_POP_LEFT;
      end
      default: return bld_pkg::mode_e'(roll[1:0]);
    endcase
  endfunction

  // Receiver: checks result transfers and varies its ready pattern.
  initial begin
    int unsigned rx_pattern;
    int unsigned rx_left;
    int unsigned hold_left;
    bit          hold_done;
    bit          ready_next;
    rx_pattern = RX_ALWAYS;
    rx_left    = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (rx_left == 0) begin
        rx_pattern = $urandom_range(RX_ALWAYS, RX_SLOW);
        rx_left    = $urandom_range(5, 60);
      end
      rx_left--;
      case (rx_pattern)
        RX_ALWAYS: ready_next = 1'b1;
        RX_HALF:   ready_next = ($urandom_range(0, 1) == 1);
        default:   ready_next = ($urandom_range(0, 3) == 0);
      endcase
      // Long hold-off so that the block backs up and stalls its input.
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end
      m_axis_tready <= ready_next;
    end
  end

  // Stimulus and end of run.
  initial begin
    int unsigned phase;
    int unsigned phase_left;
    sb            = new();
    burst_left    = $urandom_range(1, 12);
    sent_count    = 0;
    hold_request  = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Pops from the empty queue on both sides.
    send_request(bld_pkg::MODE_POP_LEFT, 32'h1234_5678);
    send_request(bld_pkg::MODE_POP_RIGHT, 32'hffff_ffff);
    // Left push into the empty queue, taken back from the right.
    send_request(bld_pkg::MODE_PUSH_LEFT, 32'h8000_0000);
    send_request(bld_pkg::MODE_POP_RIGHT, 32'h0);
    // Right push into the empty queue, then fill to the last slot.
    send_request(bld_pkg::MODE_PUSH_RIGHT, 32'h7fff_ffff);
    send_request(bld_pkg::MODE_PUSH_RIGHT, 32'h0000_0000);
    send_request(bld_pkg::MODE_PUSH_RIGHT, 32'hffff_ffff);
    send_request(bld_pkg::MODE_PUSH_RIGHT, 32'haaaa_aaaa);
    send_request(bld_pkg::MODE_PUSH_RIGHT, 32'h5555_5555);
    send_request(bld_pkg::MODE_PUSH_RIGHT, 32'h0000_0001);
    send_request(bld_pkg::MODE_PUSH_RIGHT, 32'hffff_fffe);
    send_request(bld_pkg::MODE_PUSH_RIGHT, 32'h8000_0000);
    // Both pushes refused on a full queue whose front is at slot 0.
    send_request(bld_pkg::MODE_PUSH_RIGHT, 32'h1111_1111);
    send_request(bld_pkg::MODE_PUSH_LEFT, 32'h2222_2222);
    // Open room at the left and use it up again.
    send_request(bld_pkg::MODE_POP_LEFT, 32'h0);
    send_request(bld_pkg::MODE_POP_LEFT, 32'h0);
    send_request(bld_pkg::MODE_PUSH_LEFT, 32'hdead_beef);
    send_request(bld_pkg::MODE_PUSH_LEFT, 32'h7fff_ffff);
    send_request(bld_pkg::MODE_PUSH_LEFT, 32'h3333_3333);
    // Drain from both ends until the last element leaves, then one more pop.
    for (int i = 0; i < 4; i++) begin
      send_request(bld_pkg::MODE_POP_RIGHT, 32'h0);
      send_request(bld_pkg::MODE_POP_LEFT, 32'hffff_ffff);
    end
    send_request(bld_pkg::MODE_POP_LEFT, 32'h0);

    // Random part in phases of varying mix.
    phase      = PHASE_FILL;
    phase_left = 0;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase      = $urandom_range(PHASE_FILL, PHASE_SIDED);
        phase_left = $urandom_range(6, 40);
      end
      phase_left--;
      send_request(pick_mode(phase), pick_value());
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("bounded_linear_deque_core test passed");
    end else begin
      $display("bounded_linear_deque_core test failed");
    end
    $finish;
  end

endmodule
